[hw/rtl/fwfsi_pkg.sv]
// ----------------------------------------------------------------------------
// fwfsi_pkg: shared types and constants
// Word layouts, command and status codes for the FIFO with fourth-slot insert.
// ----------------------------------------------------------------------------
package fwfsi_pkg;

  localparam int DEPTH      = 16;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int INSERT_POS = 3;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [DATA_W-1:0] data_in;
  } req_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    status_t           status;
    logic              is_empty;
    logic [CNT_W-1:0]  level;
  } rsp_word_t;

endpackage

[hw/rtl/fifo_with_fourth_slot_insert.sv]
// ----------------------------------------------------------------------------
// fifo_with_fourth_slot_insert: 16-deep queue with a priority insert
// Circular buffer in a single-port-write, registered-read store, driven by a
// small sequencer that moves entries one by one (read, then write) on insert.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready, req): one command word - push at tail,
//   insert as fourth from head, pop head or clear.
//   rsp channel (rsp_valid/rsp_ready, rsp): exactly one result word per
//   command - popped data, status, empty flag and fill level after the step.
// Steps, from acceptance to rsp_valid:
//   push, clear, insert with three or fewer held, or any rejected command:
//     straight to the result state;
//   pop: one registered read of the store, then the result;
//   insert behind the third entry: each later entry is read then written
//     back one slot through the shared address adder and the single store
//     port, then the new word is written into the fourth slot.
//   One command is in flight at a time: req_ready is high only when the
//   sequencer is idle, so a new word is taken the cycle after a result leaves.
// Reset clears the fill level and head pointer; stored words are not cleared.
// A stalled receiver simply holds the result in the output register, and no
// new request is taken until it goes.
// ----------------------------------------------------------------------------
module fifo_with_fourth_slot_insert (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  fwfsi_pkg::req_word_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output fwfsi_pkg::rsp_word_t rsp
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_POP_WAIT = 6'b000010,
    S_SHIFT_RD = 6'b000100,
    S_SHIFT_WR = 6'b001000,
    S_INS_WR   = 6'b010000,
    S_RESULT   = 6'b100000
  } state_t;

  state_t                              state, state_next;
  logic [fwfsi_pkg::PTR_W-1:0]         head;
  logic [fwfsi_pkg::CNT_W-1:0]         count;
  logic [fwfsi_pkg::CNT_W-1:0]         idx;
  logic [fwfsi_pkg::DATA_W-1:0]        word;
  logic [fwfsi_pkg::DATA_W-1:0]        rd_data;
  logic [fwfsi_pkg::DATA_W-1:0]        mem [fwfsi_pkg::DEPTH];

  logic                                accept;
  logic                                is_full;
  logic                                direct_push;
  logic [fwfsi_pkg::CNT_W-1:0]         offset;
  logic [fwfsi_pkg::PTR_W-1:0]         addr;
  logic                                wr_en;
  logic [fwfsi_pkg::DATA_W-1:0]        wr_data;
  logic [fwfsi_pkg::CNT_W-1:0]         idx_dec;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_RESULT);
  assign accept    = req_valid & req_ready;
  assign is_full   = (count >= fwfsi_pkg::CNT_W'(fwfsi_pkg::DEPTH));
  assign idx_dec   = idx - fwfsi_pkg::CNT_W'(1);

  // Push lands straight at the tail; so does an insert into a short queue.
  assign direct_push = !is_full &&
                       ((req.command == fwfsi_pkg::CMD_PUSH) ||
                        ((req.command == fwfsi_pkg::CMD_INSERT) &&
                         (count <= fwfsi_pkg::CNT_W'(fwfsi_pkg::INSERT_POS))));

  // Shared address unit: logical offset from head to physical slot.
  always_comb begin
    case (state)
      S_IDLE:     offset = (req.command == fwfsi_pkg::CMD_POP) ? '0 : count;
      S_SHIFT_RD: offset = idx_dec;
      S_SHIFT_WR: offset = idx;
      S_INS_WR:   offset = fwfsi_pkg::CNT_W'(fwfsi_pkg::INSERT_POS);
      default:    offset = '0;
    endcase
  end

  assign addr = head + offset[fwfsi_pkg::PTR_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_data = word;
    case (state)
      S_IDLE: begin
        wr_en   = accept && direct_push;
        wr_data = req.data_in;
      end
      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      S_INS_WR: begin
        wr_en = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Word store: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((req.command == fwfsi_pkg::CMD_POP) && (count != '0)) begin
            state_next = S_POP_WAIT;
          end else if ((req.command == fwfsi_pkg::CMD_INSERT) && !is_full &&
                       !direct_push) begin
            state_next = S_SHIFT_RD;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_POP_WAIT: state_next = S_RESULT;
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (idx_dec == fwfsi_pkg::CNT_W'(fwfsi_pkg::INSERT_POS)) begin
          state_next = S_INS_WR;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_INS_WR: state_next = S_RESULT;
      S_RESULT: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.command)
              fwfsi_pkg::CMD_POP:   ;
              fwfsi_pkg::CMD_CLEAR: count <= '0;
              default: begin
                if (direct_push) begin
                  count <= count + fwfsi_pkg::CNT_W'(1);
                end
              end
            endcase
          end
        end
        S_POP_WAIT: begin
          head  <= head + fwfsi_pkg::PTR_W'(1);
          count <= count - fwfsi_pkg::CNT_W'(1);
        end
        S_INS_WR: count <= count + fwfsi_pkg::CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Payload registers: working word, shift index and the result word.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          word         <= req.data_in;
          idx          <= count;
          rsp.data_out <= '0;
          case (req.command)
            fwfsi_pkg::CMD_POP: begin
              if (count == '0) begin
                rsp.status <= fwfsi_pkg::ST_EMPTY;
              end else begin
                rsp.status <= fwfsi_pkg::ST_OK;
              end
              rsp.level    <= count;
              rsp.is_empty <= (count == '0);
            end
            fwfsi_pkg::CMD_CLEAR: begin
              rsp.status   <= fwfsi_pkg::ST_OK;
              rsp.level    <= '0;
              rsp.is_empty <= 1'b1;
            end
            default: begin
              if (is_full) begin
                rsp.status   <= fwfsi_pkg::ST_FULL;
                rsp.level    <= count;
                rsp.is_empty <= 1'b0;
              end else begin
                // Any accepted push or insert leaves one more entry.
                rsp.status   <= fwfsi_pkg::ST_OK;
                rsp.level    <= count + fwfsi_pkg::CNT_W'(1);
                rsp.is_empty <= 1'b0;
              end
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        rsp.data_out <= rd_data;
        rsp.level    <= count - fwfsi_pkg::CNT_W'(1);
        rsp.is_empty <= (count == fwfsi_pkg::CNT_W'(1));
      end
      S_SHIFT_WR: idx <= idx_dec;
      default: ;
    endcase
  end

endmodule

[test/fifo_with_fourth_slot_insert_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_fourth_slot_insert_tb: self-checking bench for the insert queue
// Drives push, insert, pop and clear words through the request channel with
// random idling on both sides. Results are checked against a queue model that
// tracks the held words and predicts data, status, empty flag and level.
// ----------------------------------------------------------------------------
module fifo_with_fourth_slot_insert_tb;
  import fwfsi_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_WORDS = 1800;
  localparam int PHASE_LEN    = 50;   // words per traffic mix
  localparam int CALM_TAIL    = 200;  // last words run with no idling
  localparam int QUIET_LIMIT  = 1000; // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 40;   // idle wait after the last result

  typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} mix_t;

  // Queue model plus the results it still owes the checker.
  class queue_predictor;
    logic [DATA_W-1:0] held_words[$];
    rsp_word_t         owed_results[$];
    int                mismatches = 0;

    function void note_command(req_word_t w);
      rsp_word_t r;
      r        = '0;
      r.status = ST_OK;
      case (w.command)
        CMD_PUSH, CMD_INSERT: begin
          if (held_words.size() >= DEPTH)
            r.status = ST_FULL;
          else if (w.command == CMD_INSERT && held_words.size() > INSERT_POS)
            held_words.insert(INSERT_POS, w.data_in);
          else
            held_words.push_back(w.data_in);
        end
        CMD_POP: begin
          if (held_words.size() == 0)
            r.status = ST_EMPTY;
          else
            r.data_out = held_words.pop_front();
        end
        default: held_words.delete();
      endcase
      r.is_empty = (held_words.size() == 0);
      r.level    = CNT_W'(held_words.size());
      owed_results.push_back(r);
    endfunction

    function void check_result(rsp_word_t got);
      rsp_word_t want;
      if (owed_results.size() == 0) begin
        $error("result word with nothing outstanding: %h", got);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      if (got.data_out !== want.data_out) begin
        $error("data_out: expected %h, got %h", want.data_out, got.data_out);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
        mismatches++;
      end
      if (got.level !== want.level) begin
        $error("level: expected %0d, got %0d", want.level, got.level);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  logic           idle_on     = 1'b1;
  int             stall_left  = 0;
  int             quiet_count = 0;
  queue_predictor model       = new;

  fifo_with_fourth_slot_insert u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Offer one request word, with an optional idle burst first; returns once
  // the word has been taken. valid is left high so back-to-back words need no
  // second assignment in the accepting step.
  task automatic send_word(cmd_t c, logic [DATA_W-1:0] d);
    req_word_t w;
    w.command = c;
    w.data_in = d;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    model.note_command(w);
  endtask

  // Mostly random words, with zero, all-ones and walking-one patterns mixed in.
  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Fill phases drive the queue into full, drain phases into empty; clears
  // stay rare so the deep insert positions get exercised.
  function automatic cmd_t pick_command(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 45) return CMD_PUSH;
        if (r < 80) return CMD_INSERT;
        if (r < 98) return CMD_POP;
      end
      MIX_DRAIN: begin
        if (r < 15) return CMD_PUSH;
        if (r < 30) return CMD_INSERT;
        if (r < 98) return CMD_POP;
      end
      default: begin
        if (r < 30) return CMD_PUSH;
        if (r < 55) return CMD_INSERT;
        if (r < 97) return CMD_POP;
      end
    endcase
    return CMD_CLEAR;
  endfunction

  // Result side: check every word taken, then pick ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready)
      model.check_result(rsp);
    if (stall_left > 0)
      stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 3);
    rsp_ready <= !rst && stall_left == 0;
  end

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    mix_t mix;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: pop and clear on an empty queue, insert with three or fewer
    // held (acts as a tail push), insert behind the third word, data extremes.
    send_word(CMD_POP,    32'h0000_0000);
    send_word(CMD_INSERT, 32'h0000_0000);
    send_word(CMD_PUSH,   32'hFFFF_FFFF);
    send_word(CMD_INSERT, 32'hA5A5_A5A5);
    send_word(CMD_PUSH,   32'h0000_0001);
    send_word(CMD_INSERT, 32'h1234_5678);
    send_word(CMD_INSERT, 32'h8000_0000);
    send_word(CMD_PUSH,   32'h5A5A_5A5A);
    send_word(CMD_POP,    32'hFFFF_FFFF);
    send_word(CMD_POP,    32'h0000_0000);
    send_word(CMD_INSERT, 32'hDEAD_BEEF);
    send_word(CMD_CLEAR,  32'hFFFF_FFFF);
    send_word(CMD_CLEAR,  32'h0000_0000);
    send_word(CMD_POP,    32'h0000_0000);
    send_word(CMD_PUSH,   32'h7FFF_FFFF);
    send_word(CMD_INSERT, 32'hFFFF_FFFF);
    send_word(CMD_POP,    32'h0000_0000);

    // Random: mixes rotate so runs are driven toward both full and empty.
    mix = MIX_FILL;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % PHASE_LEN == 0)
        mix = mix_t'((i / PHASE_LEN) % 3);
      if (i == RANDOM_WORDS - CALM_TAIL)
        idle_on <= 1'b0;
      send_word(pick_command(mix), random_word());
    end
    req_valid <= 1'b0;

    while (model.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.mismatches == 0 && model.outstanding() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
